### rtl/sidta_pkg.sv
package sidta_pkg;

   localparam int ValueWidth  = 32;
   localparam int CharWidth   = 8;
   localparam int CountWidth  = 4;
   localparam int DigitWidth  = 4;
   localparam int NumDigits   = 10;
   localparam int BcdWidth    = NumDigits * DigitWidth;
   localparam int BitsPerStep = 4;
   localparam int ConvSteps   = ValueWidth / BitsPerStep;
   localparam int StepWidth   = $clog2(ConvSteps);

   localparam logic [CharWidth-1:0] CharMinus = 8'd45;
   localparam logic [CharWidth-1:0] CharZero  = 8'd48;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic convert;
      logic align;
      logic emit;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic out_free;
      logic last_char;
   } status_type;

endpackage

### rtl/sidta_datapath.sv
module sidta_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sidta_pkg::cmd_type                cmd,
   output sidta_pkg::status_type             status,
   input  logic [sidta_pkg::ValueWidth-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sidta_pkg::CharWidth-1:0]   rsp_char_code,
   output logic                              rsp_is_last,
   output logic [sidta_pkg::CountWidth-1:0]  rsp_chars_so_far
);
   import sidta_pkg::*;

   logic                  neg_ff;
   logic [ValueWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic                  minus_ff, minus_in;
   logic [CountWidth-1:0] digits_left_ff, digits_left_in;
   logic [CountWidth-1:0] chars_ff, chars_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic [ValueWidth-1:0] bin_step;
   logic [BcdWidth-1:0]   bcd_step;
   logic [CountWidth-1:0] num_digits;
   logic [CountWidth-1:0] lead_zeros;
   logic                  emit_last;

   // Four double-dabble iterations per cycle: adjust every BCD digit, then shift in one bit.
   always_comb begin
      logic [BcdWidth-1:0]   bcd_v;
      logic [ValueWidth-1:0] bin_v;
      bcd_v = bcd_ff;
      bin_v = bin_ff;
      for (int s = 0; s < BitsPerStep; s++) begin
         for (int d = 0; d < NumDigits; d++) begin
            if (bcd_v[d*DigitWidth +: DigitWidth] >= 4'd5) begin
               bcd_v[d*DigitWidth +: DigitWidth] = bcd_v[d*DigitWidth +: DigitWidth] + 4'd3;
            end
         end
         bcd_v = {bcd_v[BcdWidth-2:0], bin_v[ValueWidth-1]};
         bin_v = {bin_v[ValueWidth-2:0], 1'b0};
      end
      bcd_step = bcd_v;
      bin_step = bin_v;
   end

   // Number of significant digits; zero still has one digit.
   always_comb begin
      num_digits = CountWidth'(1);
      for (int d = 0; d < NumDigits; d++) begin
         if (bcd_ff[d*DigitWidth +: DigitWidth] != '0) begin
            num_digits = CountWidth'(d + 1);
         end
      end
      lead_zeros = CountWidth'(NumDigits) - num_digits;
   end

   assign emit_last = !minus_ff && (digits_left_ff == CountWidth'(1));

   always_comb begin
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      minus_in       = minus_ff;
      digits_left_in = digits_left_ff;
      chars_in       = chars_ff;
      char_in        = char_ff;
      last_in        = last_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         bin_in   = req_value[ValueWidth-1] ? (~req_value + ValueWidth'(1)) : req_value;
         bcd_in   = '0;
         chars_in = '0;
      end
      if (cmd.convert) begin
         bin_in = bin_step;
         bcd_in = bcd_step;
      end
      if (cmd.align) begin
         bcd_in         = bcd_ff << {lead_zeros, 2'b00};
         digits_left_in = num_digits;
         minus_in       = neg_ff;
      end
      if (cmd.emit) begin
         if (minus_ff) begin
            char_in  = CharMinus;
            minus_in = 1'b0;
         end else begin
            char_in        = CharZero + CharWidth'(bcd_ff[BcdWidth-1 -: DigitWidth]);
            bcd_in         = bcd_ff << DigitWidth;
            digits_left_in = digits_left_ff - CountWidth'(1);
         end
         last_in      = emit_last;
         count_in     = chars_ff + CountWidth'(1);
         chars_in     = chars_ff + CountWidth'(1);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load) begin
         neg_ff <= req_value[ValueWidth-1];
      end
      bin_ff         <= bin_in;
      bcd_ff         <= bcd_in;
      minus_ff       <= minus_in;
      digits_left_ff <= digits_left_in;
      chars_ff       <= chars_in;
      char_ff        <= char_in;
      last_ff        <= last_in;
      count_ff       <= count_in;
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last_char = emit_last;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_code    = char_ff;
   assign rsp_is_last      = last_ff;
   assign rsp_chars_so_far = count_ff;

   emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("character loaded while the output register is held");

   digits_remain_on_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !minus_ff |-> digits_left_ff != '0)
      else $error("digit emitted with no digits left");

   minus_comes_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CharMinus |-> rsp_chars_so_far == CountWidth'(1))
      else $error("minus sign not at the start of the run");

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chars_so_far != '0 && rsp_chars_so_far <= CountWidth'(11))
      else $error("character count out of range");

endmodule

### rtl/sidta_controller.sv
module sidta_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output sidta_pkg::cmd_type    cmd,
   input  sidta_pkg::status_type status
);
   import sidta_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      ALIGN,
      EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic                  stall_ff, stall_in;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      stall_in    = stall_ff;
      cmd         = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               stall_in = 1'b1;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            cmd.convert = 1'b1;
            step_in     = step_ff + StepWidth'(1);
            if (step_ff == StepWidth'(ConvSteps - 1)) begin
               state_in = ALIGN;
            end
         end
         ALIGN: begin
            cmd.align = 1'b1;
            state_in  = EMIT;
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_char) begin
                  stall_in = 1'b0;
                  state_in = IDLE;
               end
            end
         end
         default: begin
            stall_in = 1'b0;
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

   stall_matches_state: assert property (@(posedge clock) disable iff (reset)
      req_stall == (state_ff != IDLE))
      else $error("input stall out of step with the controller state");

   load_starts_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == CONVERT && step_ff == '0)
      else $error("conversion did not start after a transaction");

   align_after_full_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.align |-> $past(step_ff) == StepWidth'(ConvSteps - 1))
      else $error("alignment before all bits were converted");

endmodule

### rtl/signed_int_to_decimal_ascii_unit.sv
// Converts one signed 32-bit value per input transaction into its decimal text, sent as
// one ASCII character per output transaction: a '-' for negative values, then the digits
// most significant first without leading zeros (zero gives "0"; the most negative value
// gives "-2147483648"). Each character carries a last-of-run flag and the running count
// of characters, so the last one holds the total. Each number goes through binary-to-BCD
// conversion at four bits per cycle, a step that drops leading zeros, then one character
// per cycle into the output register whenever it is free. The next value is taken as soon
// as the last character is loaded, even while that character still waits to be taken.
module signed_int_to_decimal_ascii_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sidta_pkg::ValueWidth-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sidta_pkg::CharWidth-1:0]   rsp_char_code,
   output logic                              rsp_is_last,
   output logic [sidta_pkg::CountWidth-1:0]  rsp_chars_so_far
);
   import sidta_pkg::*;

   cmd_type    cmd;
   status_type status;

   sidta_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   sidta_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_code    (rsp_char_code),
      .rsp_is_last      (rsp_is_last),
      .rsp_chars_so_far (rsp_chars_so_far)
   );

endmodule

### bench/tb.sv
module tb;
   import sidta_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomItems = 140;
   localparam int ReportLimit = 10;
   localparam int DrainCycles = 40;
   localparam int Radix       = 10;

   typedef struct packed {
      logic [CharWidth-1:0]  code;
      logic                  last;
      logic [CountWidth-1:0] count;
   } text_char_type;

   typedef struct {
      logic [ValueWidth-1:0] value;
      string                 text;
   } directed_row_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [ValueWidth-1:0] req_value   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [CharWidth-1:0]  rsp_char_code;
   logic                  rsp_is_last;
   logic [CountWidth-1:0] rsp_chars_so_far;

   text_char_type pending_chars[$];
   int            error_count   = 0;
   int            cycle_count   = 0;
   logic          quiet_stretch = 1'b0;

   signed_int_to_decimal_ascii_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_code    (rsp_char_code),
      .rsp_is_last      (rsp_is_last),
      .rsp_chars_so_far (rsp_chars_so_far)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Works out the characters of one value: sign first, then the digits of the
   // unsigned magnitude, most significant first.
   function automatic void predict_decimal_text(input logic [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] magnitude;
      logic [DigitWidth-1:0] digits[NumDigits];
      int                    num_digits;
      int                    total;
      int                    position;
      magnitude  = value[ValueWidth-1] ? (~value + 1'b1) : value;
      num_digits = 0;
      do begin
         digits[num_digits] = DigitWidth'(magnitude % Radix);
         magnitude          = magnitude / Radix;
         num_digits++;
      end while (magnitude != 0 && num_digits < NumDigits);
      total    = num_digits + (value[ValueWidth-1] ? 1 : 0);
      position = 0;
      if (value[ValueWidth-1]) begin
         pending_chars.push_back('{CharMinus, position + 1 == total,
                                   CountWidth'(position + 1)});
         position++;
      end
      for (int i = num_digits - 1; i >= 0; i--) begin
         pending_chars.push_back('{CharZero + CharWidth'(digits[i]), position + 1 == total,
                                   CountWidth'(position + 1)});
         position++;
      end
   endfunction

   function automatic void expect_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_chars.push_back('{CharWidth'(text[i]), i == text.len() - 1,
                                   CountWidth'(i + 1)});
      end
   endfunction

   // Called at a falling edge. An empty text means the predictor supplies the
   // expected characters.
   task automatic send_value(input logic [ValueWidth-1:0] value, input string text);
      while (!quiet_stretch && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (text.len() == 0) begin
         predict_decimal_text(value);
      end else begin
         expect_text(text);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < 10);
   end

   always @(posedge clock) begin
      text_char_type seen;
      text_char_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_char_code, rsp_is_last, rsp_chars_so_far};
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= ReportLimit) begin
               $display("unexpected character: char %0d last %0b count %0d",
                        seen.code, seen.last, seen.count);
            end
         end else begin
            wanted = pending_chars.pop_front();
            if (seen !== wanted) begin
               error_count++;
               if (error_count <= ReportLimit) begin
                  $display("mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d (char/last/count)",
                           wanted.code, wanted.last, wanted.count,
                           seen.code, seen.last, seen.count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      directed_row_type      rows[$];
      logic [ValueWidth-1:0] value;
      int                    digit_count;
      longint                low;
      longint                high;
      longint                draw;
      longint                magnitude;

      rows.push_back('{32'h0000_0000, "0"});
      rows.push_back('{32'h0000_0001, "1"});
      rows.push_back('{32'hffff_ffff, "-1"});
      rows.push_back('{32'h7fff_ffff, "2147483647"});
      rows.push_back('{32'h8000_0000, "-2147483648"});
      rows.push_back('{32'h8000_0001, "-2147483647"});
      rows.push_back('{32'd9, "9"});
      rows.push_back('{32'd10, ""});
      rows.push_back('{-32'sd9, ""});
      rows.push_back('{-32'sd10, ""});
      rows.push_back('{32'd99, ""});
      rows.push_back('{32'd100, ""});
      rows.push_back('{32'd999999999, ""});
      rows.push_back('{32'd1000000000, ""});
      rows.push_back('{-32'sd1000000000, ""});
      rows.push_back('{32'd1234567890, ""});
      rows.push_back('{-32'sd1234567890, ""});
      rows.push_back('{32'h5555_5555, ""});
      rows.push_back('{32'haaaa_aaaa, ""});
      rows.push_back('{32'd7, ""});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_value(rows[i].value, rows[i].text);
      end

      for (int n = 0; n < RandomItems; n++) begin
         quiet_stretch = (n >= 60 && n < 100);
         // Let the unit drain completely once before sending on.
         if (n == 120) begin
            while (pending_chars.size() != 0) begin
               req_valid <= 1'b0;
               @(negedge clock);
            end
         end
         case ($urandom_range(0, 7))
            0, 1: value = $urandom;
            2: begin
               case ($urandom_range(0, 3))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7fff_ffff;
                  2: value = 32'h0000_0000;
                  default: value = 32'hffff_ffff;
               endcase
            end
            default: begin
               // Spread values evenly over digit counts so that short runs are common.
               digit_count = $urandom_range(1, NumDigits);
               low         = (digit_count == 1) ? 0 : longint'(Radix) ** (digit_count - 1);
               high        = longint'(Radix) ** digit_count - 1;
               if (high > 64'd2147483647) begin
                  high = 64'd2147483647;
               end
               draw      = {32'd0, $urandom};
               magnitude = low + draw % (high - low + 1);
               value     = ValueWidth'($urandom_range(0, 1) ? -magnitude : magnitude);
            end
         endcase
         send_value(value, "");
      end
      quiet_stretch = 1'b0;
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
